// ===== sv/gtpa_pkg.sv =====
package gtpa_pkg;

    // Sizes of the accumulator
    localparam int MAX_U_WORDS = 4;
    localparam int MAX_V_WORDS = 4;
    localparam int WORD_BITS   = 64;
    localparam int STORE_DEPTH = WORD_BITS * MAX_U_WORDS * MAX_V_WORDS;

    localparam int UI_W   = $clog2(MAX_U_WORDS);
    localparam int VI_W   = $clog2(MAX_V_WORDS);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int SIZE_W = 3;

    localparam logic [SIZE_W-1:0] U_WORDS_MAX = SIZE_W'(MAX_U_WORDS);
    localparam logic [SIZE_W-1:0] V_WORDS_MAX = SIZE_W'(MAX_V_WORDS);
    localparam logic [BIT_W-1:0]  BIT_LAST    = BIT_W'(WORD_BITS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST   = ADDR_W'(STORE_DEPTH - 1);

    // Configuration register indexes
    localparam logic REG_U_WORDS = 1'b0;
    localparam logic REG_V_WORDS = 1'b1;

    // Request commands
    typedef enum logic [1:0] {
        CMD_ACC = 2'd0,
        CMD_WR  = 2'd1,
        CMD_RD  = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_ACC,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic clr_wr;
        logic acc_rd;
        logic wr_word;
        logic rd_word;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic item_ok;
        cmd_t item_cmd;
        logic acc_last;
        logic out_free;
    } dp_stat_t;

    // Row r, word c sits at r*MAX_V_WORDS + c, row = u_index*WORD_BITS + bit
    function automatic logic [ADDR_W-1:0] acc_addr(
        input logic [UI_W-1:0]  ui,
        input logic [BIT_W-1:0] row,
        input logic [VI_W-1:0]  vi
    );
        acc_addr = {ui, row, vi};
    endfunction

endpackage

// ===== sv/gtpa_ctrl.sv =====
module gtpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gtpa_pkg::dp_stat_t stat,
    output gtpa_pkg::dp_cmd_t  cmd_o,
    output gtpa_pkg::state_t   state
);

    gtpa_pkg::state_t state_reg;
    gtpa_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtpa_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gtpa_pkg::ST_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = gtpa_pkg::ST_IDLE;
            end
            gtpa_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = gtpa_pkg::ST_DISPATCH;
            end
            gtpa_pkg::ST_DISPATCH:
            begin
                if (stat.item_ok && stat.item_cmd == gtpa_pkg::CMD_ACC)
                    state_next = gtpa_pkg::ST_ACC;
                else
                    state_next = gtpa_pkg::ST_DONE;
            end
            gtpa_pkg::ST_ACC:
            begin
                if (stat.acc_last)
                    state_next = gtpa_pkg::ST_DRAIN;
            end
            gtpa_pkg::ST_DRAIN:
            begin
                state_next = gtpa_pkg::ST_DONE;
            end
            gtpa_pkg::ST_DONE:
            begin
                if (stat.out_free)
                    state_next = gtpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gtpa_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_o    = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            gtpa_pkg::ST_CLEAR:
            begin
                cmd_o.clr_wr = 1'b1;
            end
            gtpa_pkg::ST_IDLE:
            begin
                in_stall        = 1'b0;
                cmd_o.load_item = in_valid;
            end
            gtpa_pkg::ST_DISPATCH:
            begin
                cmd_o.wr_word = stat.item_ok && stat.item_cmd == gtpa_pkg::CMD_WR;
                cmd_o.rd_word = stat.item_ok && stat.item_cmd == gtpa_pkg::CMD_RD;
            end
            gtpa_pkg::ST_ACC:
            begin
                cmd_o.acc_rd = 1'b1;
            end
            gtpa_pkg::ST_DRAIN:
            begin
                cmd_o = '0;
            end
            gtpa_pkg::ST_DONE:
            begin
                cmd_o.out_load = stat.out_free;
            end
            default:
            begin
                cmd_o = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ===== sv/gtpa_dp.sv =====
module gtpa_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [gtpa_pkg::SIZE_W-1:0] cfg_data,
    input  logic [1:0]                  cmd,
    input  logic [63:0]                 u_word,
    input  logic [1:0]                  u_index,
    input  logic [63:0]                 v_word,
    input  logic [1:0]                  v_index,
    input  logic [5:0]                  bit_row,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [63:0]                 read_data,
    output logic                        status,
    input  gtpa_pkg::dp_cmd_t           cmd_i,
    output gtpa_pkg::dp_stat_t          stat
);

    logic [63:0] mem [gtpa_pkg::STORE_DEPTH];

    logic [gtpa_pkg::SIZE_W-1:0] u_words_reg;
    logic [gtpa_pkg::SIZE_W-1:0] v_words_reg;

    gtpa_pkg::cmd_t              cmd_reg;
    logic [63:0]                 u_word_reg;
    logic [gtpa_pkg::UI_W-1:0]   ui_reg;
    logic [63:0]                 v_word_reg;
    logic [gtpa_pkg::VI_W-1:0]   vi_reg;
    logic [gtpa_pkg::BIT_W-1:0]  row_reg;

    logic [gtpa_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic [gtpa_pkg::BIT_W-1:0]  bit_reg;
    logic [gtpa_pkg::BIT_W-1:0]  wr_bit_reg;
    logic                        pend_reg;
    logic [63:0]                 rdata_reg;

    logic                        out_valid_reg;
    logic [63:0]                 out_data_reg;
    logic                        out_status_reg;

    logic [gtpa_pkg::SIZE_W-1:0] u_eff;
    logic [gtpa_pkg::SIZE_W-1:0] v_eff;
    logic                        item_ok;
    logic                        acc_wr;
    logic                        mem_we;
    logic [gtpa_pkg::ADDR_W-1:0] mem_waddr;
    logic [63:0]                 mem_wdata;
    logic                        mem_re;
    logic [gtpa_pkg::ADDR_W-1:0] mem_raddr;

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_words_reg <= gtpa_pkg::SIZE_W'(1);
            v_words_reg <= gtpa_pkg::SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gtpa_pkg::REG_U_WORDS: u_words_reg <= cfg_data;
                gtpa_pkg::REG_V_WORDS: v_words_reg <= cfg_data;
                default:               u_words_reg <= u_words_reg;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd_i.load_item)
        begin
            cmd_reg    <= gtpa_pkg::cmd_t'(cmd);
            u_word_reg <= u_word;
            ui_reg     <= u_index;
            v_word_reg <= v_word;
            vi_reg     <= v_index;
            row_reg    <= bit_row;
        end
    end

    // Range check, oversized registers clamp to the maximum
    always_comb
    begin
        u_eff   = (u_words_reg > gtpa_pkg::U_WORDS_MAX) ? gtpa_pkg::U_WORDS_MAX : u_words_reg;
        v_eff   = (v_words_reg > gtpa_pkg::V_WORDS_MAX) ? gtpa_pkg::V_WORDS_MAX : v_words_reg;
        item_ok = (gtpa_pkg::SIZE_W'(ui_reg) < u_eff) && (gtpa_pkg::SIZE_W'(vi_reg) < v_eff);
    end

    // Clear sweep and bit walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            bit_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            if (cmd_i.clr_wr)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd_i.load_item)
                bit_reg <= '0;
            else if (cmd_i.acc_rd)
                bit_reg <= bit_reg + 1'b1;
            pend_reg <= cmd_i.acc_rd;
        end
    end

    // Bit whose read data returns next cycle
    always_ff @(posedge clk)
    begin
        if (cmd_i.acc_rd)
            wr_bit_reg <= bit_reg;
    end

    // Memory port selection: read one row ahead, write back the row read last cycle
    always_comb
    begin
        acc_wr    = pend_reg && u_word_reg[wr_bit_reg];
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (cmd_i.clr_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd_i.wr_word)
        begin
            mem_we    = 1'b1;
            mem_waddr = gtpa_pkg::acc_addr(ui_reg, row_reg, vi_reg);
            mem_wdata = v_word_reg;
        end
        else if (acc_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = gtpa_pkg::acc_addr(ui_reg, wr_bit_reg, vi_reg);
            mem_wdata = rdata_reg ^ v_word_reg;
        end
        mem_re    = cmd_i.acc_rd || cmd_i.rd_word;
        mem_raddr = gtpa_pkg::acc_addr(ui_reg, cmd_i.acc_rd ? bit_reg : row_reg, vi_reg);
    end

    // Accumulator memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_i.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.out_load)
        begin
            out_data_reg   <= (item_ok && cmd_reg == gtpa_pkg::CMD_RD) ? rdata_reg : '0;
            out_status_reg <= !item_ok && cmd_reg != gtpa_pkg::CMD_NOP;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign status    = out_status_reg;

    // Status to controller
    always_comb
    begin
        stat.clr_last = clr_cnt_reg == gtpa_pkg::ADDR_LAST;
        stat.item_ok  = item_ok;
        stat.item_cmd = cmd_reg;
        stat.acc_last = bit_reg == gtpa_pkg::BIT_LAST;
        stat.out_free = !out_valid_reg || !out_stall;
    end

endmodule

// ===== sv/gf2_transpose_product_accumulate_unit.sv =====
// GF(2) outer-product accumulator, 256 rows x 256 bits, one 64-bit word per access.
// Request channel: in_valid / in_stall with cmd, u_word, u_index, v_word, v_index,
// bit_row. A request is taken on a clock edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall with read_data and status, one result per
// request, held stable while out_stall is high.
// Config: cfg_we, cfg_index (0 u_words, 1 v_words), cfg_data; write only when idle.
// Write, read, flagged or no-op requests go from accept through dispatch to the
// result register; accumulate adds the bit walk and a drain step before it.
// Accumulate walks the 64 bits of u_word with one read-modify-write per cycle
// on the single-read, single-write accumulator memory, reads running one row
// ahead of write-back. One request is in flight at a time; the next is taken
// the cycle after the result is loaded.
// A pending result sits in the output register; a new request can be accepted
// and worked on meanwhile, and its result waits until the register frees.
// Reset: sizes return to 1 and a sweep zeroes all 1024 accumulator words, one
// per cycle; in_stall stays high until the sweep ends.
module gf2_transpose_product_accumulate_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [gtpa_pkg::SIZE_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic [63:0]                 u_word,
    input  logic [1:0]                  u_index,
    input  logic [63:0]                 v_word,
    input  logic [1:0]                  v_index,
    input  logic [5:0]                  bit_row,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [63:0]                 read_data,
    output logic                        status
);

    gtpa_pkg::dp_cmd_t  dp_cmd;
    gtpa_pkg::dp_stat_t dp_stat;
    gtpa_pkg::state_t   state;

    gtpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (dp_stat),
        .cmd_o    (dp_cmd),
        .state    (state)
    );

    gtpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .u_word    (u_word),
        .u_index   (u_index),
        .v_word    (v_word),
        .v_index   (v_index),
        .bit_row   (bit_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data),
        .status    (status),
        .cmd_i     (dp_cmd),
        .stat      (dp_stat)
    );

    // No request taken during the clear sweep
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state == gtpa_pkg::ST_CLEAR |-> in_stall)
        else $error("request accepted during clear sweep");

    // A flagged result never carries data
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> read_data == 64'd0)
        else $error("flagged result with nonzero data");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !dp_cmd.out_load)
        else $error("result overwritten while stalled");

    // Accumulate leaves the bit walk only after its last bit
    a_acc_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state == gtpa_pkg::ST_DRAIN) |-> $past(dp_stat.acc_last))
        else $error("accumulate ended early");

endmodule
